### rtl/hte_pkg.sv
`timescale 1ns / 1ps
package hte_pkg;

    localparam int PIPE_STAGES = 32;
    localparam int SQ_ROUNDS   = 20;
    localparam int FRAC_W      = 20;

    localparam int CH_W   = 32;
    localparam int EXP_W  = 16;
    localparam int GS_W   = 25;
    localparam int OUT_W  = 16;

    localparam logic [EXP_W-1:0] EXPOSURE_RST = 16'd256;
    localparam logic [15:0]      GAMMA_RST    = 16'd7447;
    localparam int               GAMMA_SCALE  = 500;

    localparam logic       CFG_EXPOSURE = 1'b0;
    localparam logic       CFG_GAMMA    = 1'b1;

    localparam logic signed [31:0] LOG10_2_Q32    = 32'sd1292913986;
    localparam logic signed [36:0] LOG10_GAIN_Q32 = 37'sd1489440912;
    localparam logic signed [63:0] N_REF          = 64'sd444 <<< 46;
    localparam logic signed [63:0] N_TOP          = 64'sd1023 <<< 46;
    localparam logic [33:0]        Q_TOP          = 34'd1023 << 24;
    localparam logic [42:0]        W_BASE         = 43'd1023 << 24;
    localparam logic [59:0]        X_BASE         = 60'd1023 << 32;
    localparam logic [26:0]        RECIP_1023     = 27'd67174464;
    localparam logic [26:0]        DIV_1023       = 27'd1023;

    typedef struct packed {
        logic              en;
        logic [EXP_W-1:0]  exposure;
        logic [GS_W-1:0]   gscale;
    } t_chan_ctl;

endpackage

### rtl/hdr_log_tone_encoder.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle unless the output stalls; each channel pipeline holds 32 register stages,
// twenty of them one squaring multiplier each for the log2 fraction bits.
// A stalled output freezes the whole pipeline in place.
// Reset (synchronous, active low) clears valid bits and restores exposure and gamma.
module hdr_log_tone_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [95:0] i_s_axis_tdata,   // red_in, green_in, blue_in
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // red_out, green_out, blue_out
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);

    localparam int N = hte_pkg::PIPE_STAGES;

    logic                       r_vld [0:N-1];
    logic [hte_pkg::EXP_W-1:0]  r_exposure;
    logic [hte_pkg::GS_W-1:0]   r_gscale;
    logic                       w_en;
    hte_pkg::t_chan_ctl         w_ctl;

    assign w_en = !r_vld[N-1] || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_s_axis_tvalid;
            for (int i = 1; i < N; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exposure <= hte_pkg::EXPOSURE_RST;
            r_gscale   <= 25'(hte_pkg::GAMMA_RST * hte_pkg::GAMMA_SCALE);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                hte_pkg::CFG_EXPOSURE: r_exposure <= i_cfg_wdata;
                hte_pkg::CFG_GAMMA:    r_gscale   <= 25'(i_cfg_wdata) * 25'd500;
                default: ;
            endcase
        end
    end

    assign w_ctl.en       = w_en;
    assign w_ctl.exposure = r_exposure;
    assign w_ctl.gscale   = r_gscale;

    for (genvar c = 0; c < 3; c++) begin : g_ch
        hte_channel u_ch (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_chan (i_s_axis_tdata[c*32 +: 32]),
            .o_code (o_m_axis_tdata[c*16 +: 16])
        );
    end

    assign o_s_axis_tready = w_en && i_rst_n;
    assign o_m_axis_tvalid = r_vld[N-1];

endmodule

### rtl/hte_channel.sv
`timescale 1ns / 1ps
module hte_channel (
    input  logic                       i_clk,
    input  hte_pkg::t_chan_ctl         i_ctl,
    input  logic [hte_pkg::CH_W-1:0]   i_chan,
    output logic [hte_pkg::OUT_W-1:0]  o_code
);

    localparam int R = hte_pkg::SQ_ROUNDS;
    localparam int F = hte_pkg::FRAC_W;

    logic        [47:0] r_p;
    logic        [47:0] r_p2;
    logic        [5:0]  r_e2;
    logic               r_z2;
    logic        [5:0]  n_e2;

    logic        [30:0]  r_m  [0:R];
    logic        [F-1:0] r_fr [0:R];
    logic        [5:0]   r_e  [0:R];
    logic                r_z  [0:R];
    logic        [47:0]  n_norm;

    logic signed [57:0] r_lp;
    logic               r_zl;
    logic signed [6:0]  n_es;
    logic signed [25:0] n_l;

    logic signed [36:0] r_lg;
    logic               r_zg;
    logic signed [57:0] n_lgs;

    logic        [43:0] r_pl;
    logic signed [43:0] r_ph;
    logic               r_zp;

    logic signed [63:0] r_n;
    logic               r_zt;
    logic signed [63:0] n_n;

    logic        [33:0] r_q;
    logic        [33:0] n_q;
    logic        [42:0] r_w;
    logic        [25:0] r_y;
    logic        [59:0] n_x;

    logic        [15:0] r_qe;
    logic        [25:0] r_yd;
    logic        [52:0] n_prod;

    logic        [15:0] r_out;
    logic        [26:0] n_rem;

    always_comb begin
        n_e2 = '0;
        for (int i = 0; i < 48; i++) begin
            if (r_p[i]) begin
                n_e2 = 6'(i);
            end
        end
    end

    always_comb begin
        if (r_e2 >= 6'd30) begin
            n_norm = r_p2 >> (r_e2 - 6'd30);
        end else begin
            n_norm = r_p2 << (6'd30 - r_e2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_p   <= 48'(i_chan) * 48'(i_ctl.exposure);
            r_p2  <= r_p;
            r_e2  <= n_e2;
            r_z2  <= (r_p == '0);
            r_m[0]  <= n_norm[30:0];
            r_fr[0] <= '0;
            r_e[0]  <= r_e2;
            r_z[0]  <= r_z2;
        end
    end

    for (genvar k = 0; k < R; k++) begin : g_sq
        logic [61:0] w_sq;
        logic [31:0] w_s;
        assign w_sq = r_m[k] * r_m[k];
        assign w_s  = w_sq[61:30];
        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_m[k+1]  <= w_s[31] ? w_s[31:1] : w_s[30:0];
                r_fr[k+1] <= {r_fr[k][F-2:0], w_s[31]};
                r_e[k+1]  <= r_e[k];
                r_z[k+1]  <= r_z[k];
            end
        end
    end

    assign n_es  = $signed({1'b0, r_e[R]}) - 7'sd24;
    assign n_l   = $signed({n_es[5:0], r_fr[R]});
    assign n_lgs = r_lp >>> F;

    always_comb begin
        n_n = ($signed({{20{r_ph[43]}}, r_ph}) <<< 19) + $signed({20'b0, r_pl})
              + hte_pkg::N_REF;
    end

    always_comb begin
        if (r_zt || r_n < 64'sd0) begin
            n_q = '0;
        end else if (r_n > hte_pkg::N_TOP) begin
            n_q = hte_pkg::Q_TOP;
        end else begin
            n_q = r_n[55:22];
        end
    end

    assign n_x    = ({r_w, 16'b0} - 60'(r_w)) + hte_pkg::X_BASE;
    assign n_prod = 53'(r_y) * 53'(hte_pkg::RECIP_1023);
    assign n_rem  = 27'(r_yd) - (({11'b0, r_qe} << 10) - 27'(r_qe));

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_lp  <= n_l * hte_pkg::LOG10_2_Q32;
            r_zl  <= r_z[R];
            r_lg  <= 37'(n_lgs) + hte_pkg::LOG10_GAIN_Q32;
            r_zg  <= r_zl;
            r_pl  <= 44'(r_lg[18:0]) * 44'(i_ctl.gscale);
            r_ph  <= $signed(r_lg[36:19]) * $signed({1'b0, i_ctl.gscale});
            r_zp  <= r_zg;
            r_n   <= n_n;
            r_zt  <= r_zp;
            r_q   <= n_q;
            r_w   <= hte_pkg::W_BASE + ({9'b0, r_q} << 9) - ({9'b0, r_q} << 1);
            r_y   <= n_x[58:33];
            r_qe  <= n_prod[51:36];
            r_yd  <= r_y;
            r_out <= (n_rem >= hte_pkg::DIV_1023) ? r_qe + 16'd1 : r_qe;
        end
    end

    assign o_code = r_out;

endmodule
